// ----- src/tempo_locked_clock_mult_div_assert.svh -----
// Assertion macros shared by the checker of the clock multiplier/divider.
`ifndef TEMPO_LOCKED_CLOCK_MULT_DIV_ASSERT_SVH
`define TEMPO_LOCKED_CLOCK_MULT_DIV_ASSERT_SVH

// Check a consequence in the same cycle as its trigger condition.
`define TLCM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger condition.
`define TLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tlcm_pkg.sv -----
`timescale 1ns / 1ps
package tlcm_pkg;

    // Field widths
    localparam int LEVEL_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int TOL_W      = 16;
    localparam int TIMEOUT_W  = 24;
    localparam int BEAT_W     = 24;
    localparam int SUBSTEP_W  = 20;
    localparam int STEP_W     = 4;
    localparam int GATE_REM_W = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DEFAULT_PERIOD_BITS = 24;

    // Gate order: mul4, mul2, div2, div4
    localparam int NUM_GATES = 4;
    localparam int GATE_MUL4 = 0;
    localparam int GATE_MUL2 = 1;
    localparam int GATE_DIV2 = 2;
    localparam int GATE_DIV4 = 3;

    // Gate width = fraction * period >> shift (in 256ths of each gate's period)
    localparam int unsigned GATE_SHIFT [NUM_GATES] = '{10, 9, 7, 6};

    // Register reset values
    localparam logic signed [LEVEL_W-1:0] RST_HIGH_THR = 16'sd3277;
    localparam logic signed [LEVEL_W-1:0] RST_LOW_THR  = 16'sd0;
    localparam logic [FRAC_W-1:0]         RST_FRAC     = 8'd128;
    localparam logic [TOL_W-1:0]          RST_TOL      = 16'd240;
    localparam logic [TIMEOUT_W-1:0]      RST_TIMEOUT  = 24'd96000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THR  = 3'd0,
        CFG_LOW_THR   = 3'd1,
        CFG_GATE_FRAC = 3'd2,
        CFG_LOCK_TOL  = 3'd3,
        CFG_TIMEOUT   = 3'd4
    } t_cfg_idx;

    // Per-tick control from the tempo tracker to the gate bank
    typedef struct packed {
        logic                 clear;
        logic                 advance;
        logic [NUM_GATES-1:0] fire;
    } t_gate_ctrl;

endpackage

// ----- src/tlcm_gates.sv -----
`timescale 1ns / 1ps
module tlcm_gates #(
    parameter int PERIOD_BITS = tlcm_pkg::DEFAULT_PERIOD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tlcm_pkg::t_gate_ctrl           i_ctrl,
    input  logic [tlcm_pkg::FRAC_W-1:0]    i_frac,
    input  logic [PERIOD_BITS-1:0]         i_period,
    output logic [tlcm_pkg::NUM_GATES-1:0] o_gate_on
);
    import tlcm_pkg::*;

    localparam int PROD_W = PERIOD_BITS + FRAC_W;

    logic [PROD_W-1:0]     w_prod;
    logic [GATE_REM_W-1:0] w_width [NUM_GATES];
    logic [GATE_REM_W-1:0] w_dec   [NUM_GATES];
    logic [GATE_REM_W-1:0] r_rem   [NUM_GATES];
    logic [NUM_GATES-1:0]  r_on;

    // Scale the period by the width fraction once, shared by all gates
    assign w_prod = PROD_W'(i_frac) * PROD_W'(i_period);

    for (genvar g = 0; g < NUM_GATES; g++) begin : g_gate
        // Take each gate's width from its own slice of the product
        assign w_width[g] = GATE_REM_W'(w_prod >> GATE_SHIFT[g]);
        assign w_dec[g]   = (r_rem[g] != '0) ? r_rem[g] - 1'b1 : '0;

        // Count down a running gate, reload on trigger, drop on lock loss
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rem[g] <= '0;
                r_on[g]  <= 1'b0;
            end else if (i_ctrl.clear) begin
                r_rem[g] <= '0;
                r_on[g]  <= 1'b0;
            end else if (i_ctrl.advance) begin
                if (i_ctrl.fire[g]) begin
                    r_rem[g] <= w_width[g];
                    r_on[g]  <= (w_width[g] != '0);
                end else if (r_on[g]) begin
                    r_rem[g] <= w_dec[g];
                    r_on[g]  <= (w_dec[g] != '0);
                end
            end
        end
    end

    assign o_gate_on = r_on;

endmodule

// ----- src/tempo_locked_clock_mult_div.sv -----
`timescale 1ns / 1ps
// Tempo-locked clock multiplier / divider.
// Input channel (i_in_valid / o_in_ready) carries one sample tick: a signed
// clock level and a connected flag. Output channel (o_out_valid /
// i_out_ready) returns one request per tick: four gates (x4, x2, /2, /4),
// the lock flag and the locked beat period (zero while unlocked).
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the trigger
// thresholds, gate width fraction, lock tolerance and lost-clock timeout by
// index; it is always ready and should be used while the block is idle.
// The result of a tick is registered and valid in the cycle after it is accepted.
// Throughput: one tick per cycle unless the receiver stalls; the tracker
// state and gate counters are updated in one registered pass through the
// Schmitt trigger, the interval check and the width multiplier.
// The result registers hold the latest tick; a new tick is taken whenever
// the result register is empty or being drained in the same cycle, so a
// stalled receiver stalls the input and nothing is dropped.
// Reset (i_rst_n low, synchronous) restores register defaults, clears lock,
// gates and timers, and empties the result register.
module tempo_locked_clock_mult_div #(
    parameter int PERIOD_BITS = tlcm_pkg::DEFAULT_PERIOD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [tlcm_pkg::LEVEL_W-1:0]  i_clock_level,
    input  logic                                 i_clock_connected,
    // result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_gate_mul4,
    output logic                                 o_gate_mul2,
    output logic                                 o_gate_div2,
    output logic                                 o_gate_div4,
    output logic                                 o_locked,
    output logic [tlcm_pkg::BEAT_W-1:0]          o_beat_period,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tlcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlcm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tlcm_pkg::*;

    localparam int SUB_W = PERIOD_BITS - 4;

    // Configuration registers
    logic signed [LEVEL_W-1:0] r_high_thr;
    logic signed [LEVEL_W-1:0] r_low_thr;
    logic [FRAC_W-1:0]         r_frac;
    logic [TOL_W-1:0]          r_tol;
    logic [TIMEOUT_W-1:0]      r_timeout;

    // Tracker state
    logic                   r_trig,     n_trig;
    logic                   r_armed,    n_armed;
    logic                   r_lock,     n_lock;
    logic [1:0]             r_beat,     n_beat;
    logic [PERIOD_BITS-1:0] r_period,   n_period;
    logic [PERIOD_BITS-1:0] r_interval, n_interval;
    logic [SUBSTEP_W-1:0]   r_substep,  n_substep;
    logic [STEP_W-1:0]      r_step,     n_step;
    logic                   r_out_valid;

    logic                   w_in_fire;
    logic                   w_cfg_fire;
    logic                   w_rising;
    logic                   w_edge;
    logic                   w_drop;
    logic                   w_advance;
    logic [NUM_GATES-1:0]   w_fire_mask;
    logic [PERIOD_BITS-1:0] w_dev;
    logic [SUB_W-1:0]       w_sub;
    logic [SUBSTEP_W:0]     w_sub_next;
    t_gate_ctrl             w_gate_ctrl;
    logic [NUM_GATES-1:0]   w_gate_on;
    logic [31:0]            w_period_ext;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Deviation of the measured interval from the locked period
    assign w_dev = (r_interval > r_period) ? r_interval - r_period : r_period - r_interval;

    // Compute the next tracker state for one tick
    always_comb begin
        n_trig      = r_trig;
        n_armed     = r_armed;
        n_lock      = r_lock;
        n_beat      = r_beat;
        n_period    = r_period;
        n_interval  = r_interval;
        n_substep   = r_substep;
        n_step      = r_step;
        w_rising    = 1'b0;
        w_edge      = 1'b0;
        w_drop      = 1'b0;
        w_advance   = 1'b0;
        w_fire_mask = '0;
        w_sub       = '0;
        w_sub_next  = '0;

        if (!i_clock_connected) begin
            w_drop = 1'b1;
        end else begin
            // Schmitt trigger
            if (r_trig) begin
                if (i_clock_level <= r_low_thr) n_trig = 1'b0;
            end else if (i_clock_level >= r_high_thr) begin
                n_trig   = 1'b1;
                w_rising = 1'b1;
            end

            // Count an armed rising edge, lock or check the interval
            w_edge = w_rising && !r_armed;
            if (w_edge) begin
                n_armed   = 1'b1;
                n_beat    = r_beat + 2'd1;
                n_step    = '0;
                n_substep = '0;
                if (!r_lock) begin
                    if (n_beat == 2'd2) begin
                        n_lock   = 1'b1;
                        n_period = r_interval;
                    end
                end else if (32'(w_dev) > 32'(r_tol)) begin
                    n_lock = 1'b0;
                    w_drop = 1'b1;
                end
                n_interval = '0;
            end

            // Rearm once the level returns to zero or below
            if (i_clock_level <= 16'sd0) n_armed = 1'b0;

            // Step through sixteen steps per beat
            if (n_lock) begin
                w_advance = 1'b1;
                w_sub = SUB_W'(n_period >> 4);
                if (w_sub == '0) w_sub = SUB_W'(1);
                if (n_substep == '0) begin
                    w_fire_mask[GATE_MUL4] = (n_step[1:0] == 2'd0);
                    w_fire_mask[GATE_MUL2] = (n_step[2:0] == 3'd0);
                    if (w_edge) begin
                        w_fire_mask[GATE_DIV2] = !n_beat[0];
                        w_fire_mask[GATE_DIV4] = (n_beat == 2'd0);
                    end
                    n_step = n_step + 1'b1;
                end
                w_sub_next = {1'b0, n_substep} + 1'b1;
                n_substep = (32'(w_sub_next) >= 32'(w_sub)) ? '0 : w_sub_next[SUBSTEP_W-1:0];
            end

            // Advance the saturating interval timer and check for a lost clock
            if (n_interval != '1) n_interval = n_interval + 1'b1;
            if (32'(n_interval) > 32'(r_timeout)) w_drop = 1'b1;
        end

        // Drop lock and restart the beat
        if (w_drop) begin
            n_lock    = 1'b0;
            n_beat    = '0;
            n_step    = '0;
            n_substep = '0;
        end
    end

    assign w_gate_ctrl.clear   = w_in_fire && w_drop;
    assign w_gate_ctrl.advance = w_in_fire && w_advance;
    assign w_gate_ctrl.fire    = w_fire_mask;

    tlcm_gates #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_gates (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_gate_ctrl),
        .i_frac    (r_frac),
        .i_period  (n_period),
        .o_gate_on (w_gate_on)
    );

    // Hold tracker state, advance it on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig      <= 1'b0;
            r_armed     <= 1'b0;
            r_lock      <= 1'b0;
            r_beat      <= '0;
            r_period    <= '0;
            r_interval  <= '0;
            r_substep   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_trig     <= n_trig;
                r_armed    <= n_armed;
                r_lock     <= n_lock;
                r_beat     <= n_beat;
                r_period   <= n_period;
                r_interval <= n_interval;
                r_substep  <= n_substep;
                r_step     <= n_step;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= RST_HIGH_THR;
            r_low_thr  <= RST_LOW_THR;
            r_frac     <= RST_FRAC;
            r_tol      <= RST_TOL;
            r_timeout  <= RST_TIMEOUT;
        end else if (w_cfg_fire) begin
            unique case (i_cfg_index)
                CFG_HIGH_THR:  r_high_thr <= i_cfg_data[LEVEL_W-1:0];
                CFG_LOW_THR:   r_low_thr  <= i_cfg_data[LEVEL_W-1:0];
                CFG_GATE_FRAC: r_frac     <= i_cfg_data[FRAC_W-1:0];
                CFG_LOCK_TOL:  r_tol      <= i_cfg_data[TOL_W-1:0];
                CFG_TIMEOUT:   r_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Drive the result from the state left by the last tick
    assign w_period_ext  = 32'(r_period);
    assign o_out_valid   = r_out_valid;
    assign o_gate_mul4   = w_gate_on[GATE_MUL4];
    assign o_gate_mul2   = w_gate_on[GATE_MUL2];
    assign o_gate_div2   = w_gate_on[GATE_DIV2];
    assign o_gate_div4   = w_gate_on[GATE_DIV4];
    assign o_locked      = r_lock;
    assign o_beat_period = r_lock ? w_period_ext[BEAT_W-1:0] : '0;

endmodule

// ----- src/tlcm_checker.sv -----
`timescale 1ns / 1ps
`include "tempo_locked_clock_mult_div_assert.svh"
module tlcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_clock_connected,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_gate_mul4,
    input logic        o_gate_mul2,
    input logic        o_gate_div2,
    input logic        o_gate_div4,
    input logic        o_locked,
    input logic [23:0] o_beat_period
);

    // Unlocked: all gates low and no period shown
    `TLCM_ASSERT_SAME(a_unlocked_quiet, i_clk, i_rst_n, !o_locked, !o_gate_mul4 && !o_gate_mul2 && !o_gate_div2 && !o_gate_div4 && o_beat_period == 24'd0, "gates or period active while unlocked")

    // Disconnected tick: its result shows no lock and no gates
    `TLCM_ASSERT_NEXT(a_disconnect_drops, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_clock_connected, !o_locked && !o_gate_mul4 && !o_gate_mul2 && !o_gate_div2 && !o_gate_div4, "lock held after a disconnected tick")

    // Every accepted request yields a result request next cycle
    `TLCM_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid, "accepted tick gave no result")

    // Stalled result stays valid and holds its lock flag, beat period and x4 gate
    `TLCM_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_locked) && $stable(o_beat_period) && $stable(o_gate_mul4), "stalled result changed")

endmodule

bind tempo_locked_clock_mult_div tlcm_checker u_tlcm_checker (.*);
